// ----- rtl/core/bres_pkg.sv -----
// Shared types, constants and helpers for the Bresenham line rasteriser.
package bres_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;

  // Field and state widths
  localparam int X_W      = 9;
  localparam int Y_W      = 8;
  localparam int COLOUR_W = 8;
  localparam int ADDR_W   = 16;
  localparam int ERR_W    = 11;
  localparam int STEPS_W  = 9;
  localparam int MINOR_W  = 10;

  localparam logic [X_W-1:0] X_MAX = X_W'(SCREEN_WIDTH - 1);
  localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // Registered command beat
  typedef struct packed {
    opcode_t             opcode;
    logic [X_W-1:0]      start_x;
    logic [Y_W-1:0]      start_y;
    logic [X_W-1:0]      end_x;
    logic [Y_W-1:0]      end_y;
    logic [COLOUR_W-1:0] pen_colour;
  } cmd_item_t;

  // Line set-up values derived from a start command
  typedef struct packed {
    logic [X_W-1:0]          x0;
    logic [Y_W-1:0]          y0;
    logic                    step_left;
    logic                    x_major;
    logic [STEPS_W-1:0]      steps;
    logic [MINOR_W-1:0]      minor_twice;
    logic signed [ERR_W-1:0] minor_minus_major_twice;
    logic signed [ERR_W-1:0] error_init;
    logic [COLOUR_W-1:0]     colour;
  } line_setup_t;

  // Result beat
  typedef struct packed {
    logic                pixel_valid;
    logic [X_W-1:0]      pixel_x;
    logic [Y_W-1:0]      pixel_y;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                is_last;
  } pix_item_t;

  // Linear framebuffer offset, y * width + x (constant multiply)
  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'(y) * ADDR_W'(SCREEN_WIDTH);
    return row + ADDR_W'(x);
  endfunction

endpackage

// ----- rtl/core/bres_if.sv -----
// Valid/ready channel interfaces for command and pixel beats.
interface bres_cmd_if import bres_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [X_W-1:0]      start_x;
  logic [Y_W-1:0]      start_y;
  logic [X_W-1:0]      end_x;
  logic [Y_W-1:0]      end_y;
  logic [COLOUR_W-1:0] pen_colour;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, pen_colour,
                  input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, pen_colour,
                  output ready);
endinterface

interface bres_pix_if import bres_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                pixel_valid;
  logic [X_W-1:0]      pixel_x;
  logic [Y_W-1:0]      pixel_y;
  logic [ADDR_W-1:0]   pixel_address;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                is_last;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                  pixel_colour, is_last,
                  input ready);
  modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                  pixel_colour, is_last,
                  output ready);
endinterface

// ----- rtl/core/bres_setup.sv -----
// Start-command set-up: clamp, order endpoints, deltas and octant choice.
module bres_setup import bres_pkg::*; (
  input  cmd_item_t   item,
  output line_setup_t setup
);

  logic [X_W-1:0]     sx, ex, x0, x1;
  logic [Y_W-1:0]     sy, ey, y0, y1;
  logic signed [X_W:0] dx;
  logic [X_W-1:0]     adx;
  logic [Y_W-1:0]     dy;
  logic               x_major;
  logic [X_W-1:0]     major;
  logic [Y_W-1:0]     minor;

  // Clamp to the screen
  assign sx = (item.start_x > X_MAX) ? X_MAX : item.start_x;
  assign ex = (item.end_x   > X_MAX) ? X_MAX : item.end_x;
  assign sy = (item.start_y > Y_MAX) ? Y_MAX : item.start_y;
  assign ey = (item.end_y   > Y_MAX) ? Y_MAX : item.end_y;

  // Order so that y grows along the line
  always_comb begin
    if (sy > ey) begin
      x0 = ex; y0 = ey; x1 = sx; y1 = sy;
    end else begin
      x0 = sx; y0 = sy; x1 = ex; y1 = ey;
    end
  end

  // Deltas; equal deltas fall to y-major
  assign dx      = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign adx     = dx[X_W] ? X_W'(-dx) : dx[X_W-1:0];
  assign dy      = y1 - y0;
  assign x_major = adx > X_W'(dy);
  assign major   = x_major ? adx : X_W'(dy);
  // minor never exceeds dy, so it fits the y width
  assign minor   = x_major ? dy : adx[Y_W-1:0];

  always_comb begin
    setup.x0          = x0;
    setup.y0          = y0;
    setup.step_left   = dx[X_W] || (dx == '0);
    setup.x_major     = x_major;
    setup.steps       = STEPS_W'(major);
    setup.minor_twice = {1'b0, minor, 1'b0};
    setup.minor_minus_major_twice = $signed({2'b00, minor, 1'b0})
                                  - $signed({1'b0, major, 1'b0});
    setup.error_init  = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major});
    setup.colour      = item.pen_colour;
  end

endmodule

// ----- rtl/core/bres_core.sv -----
// Line state registers, per-pixel step logic and the result register.
module bres_core import bres_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  cmd_item_t      item,
  output logic           item_ready,
  bres_pix_if.source     pixel
);

  line_setup_t setup;

  // Line state
  logic                    line_active, line_active_next;
  logic [X_W-1:0]          cur_x, cur_x_next;
  logic [Y_W-1:0]          cur_y, cur_y_next;
  logic signed [ERR_W-1:0] error_term, error_term_next;
  logic [STEPS_W-1:0]      steps_left, steps_left_next;
  logic [MINOR_W-1:0]      minor_twice, minor_twice_next;
  logic signed [ERR_W-1:0] minor_minus_major_twice, minor_minus_major_twice_next;
  logic                    x_major, x_major_next;
  logic                    step_left, step_left_next;
  logic [COLOUR_W-1:0]     line_colour, line_colour_next;

  // Result register
  logic      res_valid;
  pix_item_t res, res_next;
  logic      fire;
  logic      err_pos, move_x, move_y;

  bres_setup u_setup (
    .item  (item),
    .setup (setup)
  );

  assign item_ready = !res_valid || pixel.ready;
  assign fire       = item_valid && item_ready;

  assign err_pos = !error_term[ERR_W-1];
  assign move_x  = x_major || err_pos;
  assign move_y  = !x_major || err_pos;

  // Next line state and result beat
  always_comb begin
    line_active_next             = line_active;
    cur_x_next                   = cur_x;
    cur_y_next                   = cur_y;
    error_term_next              = error_term;
    steps_left_next              = steps_left;
    minor_twice_next             = minor_twice;
    minor_minus_major_twice_next = minor_minus_major_twice;
    x_major_next                 = x_major;
    step_left_next               = step_left;
    line_colour_next             = line_colour;
    res_next                     = '0;

    if (item.opcode == OP_START) begin
      cur_x_next                   = setup.x0;
      cur_y_next                   = setup.y0;
      error_term_next              = setup.error_init;
      steps_left_next              = setup.steps;
      minor_twice_next             = setup.minor_twice;
      minor_minus_major_twice_next = setup.minor_minus_major_twice;
      x_major_next                 = setup.x_major;
      step_left_next               = setup.step_left;
      line_colour_next             = setup.colour;
      line_active_next             = (setup.steps != '0);
    end else if (line_active) begin
      if (move_x) begin
        cur_x_next = step_left ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        cur_y_next = cur_y + 1'b1;
      end
      error_term_next  = err_pos ? error_term + minor_minus_major_twice
                                 : error_term + $signed({1'b0, minor_twice});
      steps_left_next  = steps_left - 1'b1;
      line_active_next = (steps_left_next != '0);
    end

    // Pixel out unless a step arrives with no line running
    if (item.opcode == OP_START || line_active) begin
      res_next.pixel_valid   = 1'b1;
      res_next.pixel_x       = cur_x_next;
      res_next.pixel_y       = cur_y_next;
      res_next.pixel_address = pixel_addr(cur_x_next, cur_y_next);
      res_next.pixel_colour  = line_colour_next;
      res_next.is_last       = (steps_left_next == '0);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active             <= 1'b0;
      cur_x                   <= '0;
      cur_y                   <= '0;
      error_term              <= '0;
      steps_left              <= '0;
      minor_twice             <= '0;
      minor_minus_major_twice <= '0;
      x_major                 <= 1'b0;
      step_left               <= 1'b0;
      line_colour             <= '0;
    end else if (fire) begin
      line_active             <= line_active_next;
      cur_x                   <= cur_x_next;
      cur_y                   <= cur_y_next;
      error_term              <= error_term_next;
      steps_left              <= steps_left_next;
      minor_twice             <= minor_twice_next;
      minor_minus_major_twice <= minor_minus_major_twice_next;
      x_major                 <= x_major_next;
      step_left               <= step_left_next;
      line_colour             <= line_colour_next;
    end
  end

  // Result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_ready) begin
      res_valid <= item_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign pixel.valid         = res_valid;
  assign pixel.pixel_valid   = res.pixel_valid;
  assign pixel.pixel_x       = res.pixel_x;
  assign pixel.pixel_y       = res.pixel_y;
  assign pixel.pixel_address = res.pixel_address;
  assign pixel.pixel_colour  = res.pixel_colour;
  assign pixel.is_last       = res.is_last;

  // Active flag tracks the remaining step count
  a_active_matches_steps: assert property (@(posedge clk) disable iff (rst)
    line_active == (steps_left != '0))
    else $error("line_active disagrees with steps_left");

  // A step with no line running leaves the line state alone
  a_idle_step_holds: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OP_STEP && !line_active
    |=> $stable(cur_x) && $stable(cur_y) && $stable(error_term))
    else $error("idle step disturbed line state");

  // The last pixel of a line ends it
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.pixel_valid && res_next.is_last |=> !line_active)
    else $error("line still active after last pixel");

  // An empty result carries zero fields
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.pixel_valid
    |-> res.pixel_x == '0 && res.pixel_address == '0 && !res.is_last)
    else $error("empty result carries data");

endmodule

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// Bresenham line rasteriser top level: command register feeding the step core.
// A command beat passes through the command register and then the result register to the pixel side.
// Throughput: one command and one pixel beat per cycle unless pixel.ready stalls; the single step
// add and compare in the core, between the command register and the result register, sets this.
// Reset (rst, synchronous): no line active, both registers empty, state cleared.
module bresenham_line_rasterizer import bres_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bres_cmd_if.sink   cmd,
  bres_pix_if.source pixel
);

  logic      in_valid;
  cmd_item_t in_item;
  logic      core_ready;

  assign cmd.ready = !in_valid || core_ready;

  // Command register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  // Command register payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.opcode     <= opcode_t'(cmd.opcode);
      in_item.start_x    <= cmd.start_x;
      in_item.start_y    <= cmd.start_y;
      in_item.end_x      <= cmd.end_x;
      in_item.end_y      <= cmd.end_y;
      in_item.pen_colour <= cmd.pen_colour;
    end
  end

  bres_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (in_item),
    .item_ready (core_ready),
    .pixel      (pixel)
  );

endmodule

// ----- sim/tb_bresenham_line_rasterizer.sv -----
// Self-checking testbench for the Bresenham line rasteriser: random lines, stalls, scoreboard.
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;
  import bres_pkg::*;

  localparam int IDLE_LIMIT  = 1000; // cycles with no beat on either side
  localparam int HOLD_CYCLES = 60;   // long receiver hold-off
  localparam int TAIL_ITEMS  = 60;   // no new idling once fewer commands than this remain

  logic clk = 1'b0;
  logic rst = 1'b1;

  bres_cmd_if cmd_bus ();
  bres_pix_if pix_bus ();

  bresenham_line_rasterizer u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_bus),
    .pixel (pix_bus)
  );

  // Clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cmd_item_t cmd_q[$];      // commands still to be offered
  pix_item_t pixel_exp_q[$]; // predicted pixel beats, oldest first

  int  errors      = 0;
  int  cmds_taken  = 0;
  int  idle_cycles = 0;
  int  cyc_cnt     = 0;
  bit  cmd_fire    = 1'b0;
  bit  pix_fire    = 1'b0;

  // Predicted line state
  bit                      ln_active;
  logic [X_W-1:0]          ln_x;
  logic [Y_W-1:0]          ln_y;
  logic signed [ERR_W-1:0] ln_err;
  logic [STEPS_W-1:0]      ln_left;
  logic [MINOR_W-1:0]      ln_minor2;
  logic signed [ERR_W-1:0] ln_diff2;
  bit                      ln_xmajor;
  bit                      ln_go_left;
  logic [COLOUR_W-1:0]     ln_colour;

  // Advance the predicted line by one command and return the pixel it yields
  function automatic pix_item_t rasterise_beat(input cmd_item_t c);
    pix_item_t r;
    int x0, y0, x1, y1, t, dx, dy, major, minor, addr;
    r = '0;
    if (c.opcode == OP_START) begin
      x0 = int'((c.start_x > X_MAX) ? X_MAX : c.start_x);
      y0 = int'((c.start_y > Y_MAX) ? Y_MAX : c.start_y);
      x1 = int'((c.end_x > X_MAX) ? X_MAX : c.end_x);
      y1 = int'((c.end_y > Y_MAX) ? Y_MAX : c.end_y);
      // order endpoints so y grows
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
        t = x0; x0 = x1; x1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      ln_go_left = !(dx > 0);
      if (dx < 0) dx = -dx;
      ln_xmajor = dx > dy;
      major = ln_xmajor ? dx : dy;
      minor = ln_xmajor ? dy : dx;
      ln_minor2 = MINOR_W'(2 * minor);
      ln_diff2  = ERR_W'(2 * minor - 2 * major);
      ln_err    = ERR_W'(2 * minor - major);
      ln_left   = STEPS_W'(major);
      ln_x      = X_W'(x0);
      ln_y      = Y_W'(y0);
      ln_colour = c.pen_colour;
      ln_active = major != 0;
    end else begin
      if (!ln_active) return r;
      // minor axis move when the decision variable says so
      if (ln_err >= 0) begin
        if (ln_xmajor) ln_y = ln_y + 1'b1;
        else ln_x = ln_go_left ? ln_x - 1'b1 : ln_x + 1'b1;
        ln_err = ln_err + ln_diff2;
      end else begin
        ln_err = ln_err + $signed({1'b0, ln_minor2});
      end
      // major axis always moves
      if (ln_xmajor) ln_x = ln_go_left ? ln_x - 1'b1 : ln_x + 1'b1;
      else ln_y = ln_y + 1'b1;
      ln_left = ln_left - 1'b1;
      if (ln_left == 0) ln_active = 1'b0;
    end
    addr = int'(ln_y) * SCREEN_WIDTH + int'(ln_x);
    r.pixel_valid   = 1'b1;
    r.pixel_x       = ln_x;
    r.pixel_y       = ln_y;
    r.pixel_address = ADDR_W'(addr);
    r.pixel_colour  = ln_colour;
    r.is_last       = ln_left == 0;
    return r;
  endfunction

  task automatic push_cmd(input opcode_t op, input int sx, input int sy, input int ex,
                          input int ey, input int col);
    cmd_item_t c;
    c.opcode     = op;
    c.start_x    = X_W'(sx);
    c.start_y    = Y_W'(sy);
    c.end_x      = X_W'(ex);
    c.end_y      = Y_W'(ey);
    c.pen_colour = COLOUR_W'(col);
    cmd_q.push_back(c);
  endtask

  task automatic push_steps(input int n);
    repeat (n) push_cmd(OP_STEP, $urandom_range(0, 511), $urandom_range(0, 255),
                        $urandom_range(0, 511), $urandom_range(0, 255),
                        $urandom_range(0, 255));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Stimulus
  initial begin
    int kind, sx, sy, ex, ey, cx0, cy0, cx1, cy1, major, n, pick;
    // directed: idle step, single point, clamped horizontal, diagonal, vertical,
    // swapped endpoints with abandon, full-screen diagonal with abandon
    push_cmd(OP_STEP, 0, 0, 0, 0, 0);
    push_cmd(OP_START, 0, 0, 0, 0, 0);
    push_cmd(OP_STEP, 511, 255, 511, 255, 255);
    push_cmd(OP_START, 511, 255, 300, 255, 255);
    push_steps(3);
    push_cmd(OP_START, 0, 0, 5, 5, 8'hA5);
    push_steps(6);
    push_cmd(OP_START, 10, 0, 10, 3, 8'h5A);
    push_steps(3);
    push_cmd(OP_START, 300, 199, 310, 190, 1);
    push_steps(3);
    push_cmd(OP_START, 0, 199, 319, 0, 8'h80);
    push_steps(2);

    // random: mostly whole lines, some cut short or overrun, some noise
    while (cmd_q.size() < 545) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        push_cmd(opcode_t'($urandom_range(0, 1)), $urandom_range(0, 511),
                 $urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 255));
      end else begin
        if (kind < 24) begin
          sx = $urandom_range(0, 511);
          sy = $urandom_range(0, 255);
          ex = $urandom_range(0, 511);
          ey = $urandom_range(0, 255);
        end else begin
          sx = $urandom_range(0, 319);
          sy = $urandom_range(0, 199);
          ex = sx + $urandom_range(0, 30) - 15;
          ey = sy + $urandom_range(0, 24) - 12;
          if (ex < 0) ex = 0;
          if (ex > 319) ex = 319;
          if (ey < 0) ey = 0;
          if (ey > 199) ey = 199;
        end
        push_cmd(OP_START, sx, sy, ex, ey, $urandom_range(0, 255));
        cx0 = (sx > 319) ? 319 : sx;
        cy0 = (sy > 199) ? 199 : sy;
        cx1 = (ex > 319) ? 319 : ex;
        cy1 = (ey > 199) ? 199 : ey;
        major = (cx1 > cx0) ? cx1 - cx0 : cx0 - cx1;
        if (((cy1 > cy0) ? cy1 - cy0 : cy0 - cy1) > major)
          major = (cy1 > cy0) ? cy1 - cy0 : cy0 - cy1;
        pick = $urandom_range(0, 9);
        if (pick < 7) n = major;
        else if (pick < 9) n = $urandom_range(0, major);
        else n = major + $urandom_range(1, 3);
        // long lines are mostly cut short to keep the run bounded
        if (kind < 24 && n > 20 && $urandom_range(0, 3) != 0) n = $urandom_range(0, 20);
        // keep the total close to the intended run length
        if (n > 560 - cmd_q.size()) n = 560 - cmd_q.size();
        push_steps(n);
      end
    end
  end

  // Initial pin values and reset
  initial begin
    cmd_bus.valid      = 1'b0;
    cmd_bus.opcode     = OP_START;
    cmd_bus.start_x    = '0;
    cmd_bus.start_y    = '0;
    cmd_bus.end_x      = '0;
    cmd_bus.end_y      = '0;
    cmd_bus.pen_colour = '0;
    pix_bus.ready      = 1'b0;
    ln_active  = 1'b0;
    ln_x       = '0;
    ln_y       = '0;
    ln_err     = '0;
    ln_left    = '0;
    ln_minor2  = '0;
    ln_diff2   = '0;
    ln_xmajor  = 1'b0;
    ln_go_left = 1'b0;
    ln_colour  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Command driver
  int        send_gap = 0;
  cmd_item_t send_beat;
  always @(negedge clk) begin
    cyc_cnt++;
    if (!rst && (!cmd_bus.valid || cmd_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        cmd_bus.valid <= 1'b0;
      end else if (cmd_q.size() >= TAIL_ITEMS && (cyc_cnt % 150) >= 40 &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
        cmd_bus.valid <= 1'b0;
      end else begin
        send_beat = cmd_q.pop_front();
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= send_beat.opcode;
        cmd_bus.start_x    <= send_beat.start_x;
        cmd_bus.start_y    <= send_beat.start_y;
        cmd_bus.end_x      <= send_beat.end_x;
        cmd_bus.end_y      <= send_beat.end_y;
        cmd_bus.pen_colour <= send_beat.pen_colour;
      end
    end
  end

  // Pixel receiver: short random stalls plus one long hold-off
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && cmds_taken >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_bus.ready <= 1'b0;
      end else if (cmd_q.size() < TAIL_ITEMS) begin
        pix_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_bus.ready <= 1'b0;
      end else if ((cyc_cnt % 150) >= 70 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: score pixel beats, predict from command beats, watchdog
  cmd_item_t seen_cmd;
  pix_item_t seen_pix;
  pix_item_t want_pix;
  always @(posedge clk) begin
    if (rst) begin
      cmd_fire = 1'b0;
      pix_fire = 1'b0;
    end else begin
      cmd_fire = cmd_bus.valid && cmd_bus.ready;
      pix_fire = pix_bus.valid && pix_bus.ready;
      if (pix_fire) begin
        seen_pix.pixel_valid   = pix_bus.pixel_valid;
        seen_pix.pixel_x       = pix_bus.pixel_x;
        seen_pix.pixel_y       = pix_bus.pixel_y;
        seen_pix.pixel_address = pix_bus.pixel_address;
        seen_pix.pixel_colour  = pix_bus.pixel_colour;
        seen_pix.is_last       = pix_bus.is_last;
        if (pixel_exp_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected pixel beat, expected none, actual %h", $time, seen_pix);
        end else begin
          want_pix = pixel_exp_q.pop_front();
          check_field("pixel_valid", int'(want_pix.pixel_valid), int'(seen_pix.pixel_valid));
          check_field("pixel_x", int'(want_pix.pixel_x), int'(seen_pix.pixel_x));
          check_field("pixel_y", int'(want_pix.pixel_y), int'(seen_pix.pixel_y));
          check_field("pixel_address", int'(want_pix.pixel_address),
                      int'(seen_pix.pixel_address));
          check_field("pixel_colour", int'(want_pix.pixel_colour),
                      int'(seen_pix.pixel_colour));
          check_field("is_last", int'(want_pix.is_last), int'(seen_pix.is_last));
        end
      end
      if (cmd_fire) begin
        seen_cmd.opcode     = opcode_t'(cmd_bus.opcode);
        seen_cmd.start_x    = cmd_bus.start_x;
        seen_cmd.start_y    = cmd_bus.start_y;
        seen_cmd.end_x      = cmd_bus.end_x;
        seen_cmd.end_y      = cmd_bus.end_y;
        seen_cmd.pen_colour = cmd_bus.pen_colour;
        pixel_exp_q.push_back(rasterise_beat(seen_cmd));
        cmds_taken++;
      end
      if (cmd_fire || pix_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t ns: timeout, %0d pixel beats outstanding", $time, pixel_exp_q.size());
          $display("tb_bresenham_line_rasterizer: FAIL");
          $finish;
        end
      end
    end
  end

  // End of run
  initial begin
    @(negedge rst);
    while (cmd_q.size() != 0 || cmd_bus.valid || pixel_exp_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (pixel_exp_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d pixel beats never arrived", $time, pixel_exp_q.size());
    end
    if (errors == 0) begin
      $display("tb_bresenham_line_rasterizer: PASS");
    end else begin
      $display("tb_bresenham_line_rasterizer: FAIL");
    end
    $finish;
  end

endmodule
